FILE: src/ngl_pkg.sv
package ngl_pkg;

  // Gain format: unsigned Q1.23
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 23;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h80_0000;
  localparam int INC_W     = GAIN_W + 1;

  // Configuration registers
  localparam int THR_W     = 23;
  localparam int RAMP_W    = 16;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 2;
  localparam logic [THR_W-1:0]  THR_RESET  = 23'd0;
  localparam logic [RAMP_W-1:0] RAMP_RESET = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RAMP      = 2'd1,
    REG_BYPASS    = 2'd2
  } reg_idx_t;

  // Divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(GAIN_W + 1);

  typedef struct packed {
    logic              start;
    logic [GAIN_W-1:0] num;
    logic [RAMP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] quo;
  } div_rsp_t;

  // Microcode
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DET,
    OP_BYPASS,
    OP_TARGET,
    OP_DIVWAIT,
    OP_ADVANCE,
    OP_MUL,
    OP_STORE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_CH_MORE,
    C_NOT_BYPASS,
    C_NO_DIV,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_t;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] ST_DET    = 4'd1;
  localparam logic [STEP_W-1:0] ST_BYPCHK = 4'd2;
  localparam logic [STEP_W-1:0] ST_BYP    = 4'd3;
  localparam logic [STEP_W-1:0] ST_TGT    = 4'd4;
  localparam logic [STEP_W-1:0] ST_DWAIT  = 4'd5;
  localparam logic [STEP_W-1:0] ST_ADV    = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL    = 4'd7;
  localparam logic [STEP_W-1:0] ST_STORE  = 4'd8;
  localparam logic [STEP_W-1:0] ST_EMIT   = 4'd9;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } uword_t;

  typedef struct packed {
    logic no_input;
    logic ch_more;
    logic not_bypass;
    logic no_div;
    logic div_busy;
    logic out_full;
  } status_t;

  // Jump taken when cond holds; otherwise fall through, or back to idle on last
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] addr);
    uword_t w;
    case (addr)
      ST_IDLE:   w = '{OP_LOAD,    C_NO_INPUT,   ST_IDLE,  1'b0};
      ST_DET:    w = '{OP_DET,     C_CH_MORE,    ST_DET,   1'b0};
      ST_BYPCHK: w = '{OP_NONE,    C_NOT_BYPASS, ST_TGT,   1'b0};
      ST_BYP:    w = '{OP_BYPASS,  C_ALWAYS,     ST_EMIT,  1'b0};
      ST_TGT:    w = '{OP_TARGET,  C_NO_DIV,     ST_ADV,   1'b0};
      ST_DWAIT:  w = '{OP_DIVWAIT, C_DIV_BUSY,   ST_DWAIT, 1'b0};
      ST_ADV:    w = '{OP_ADVANCE, C_NEVER,      ST_IDLE,  1'b0};
      ST_MUL:    w = '{OP_MUL,     C_NEVER,      ST_IDLE,  1'b0};
      ST_STORE:  w = '{OP_STORE,   C_CH_MORE,    ST_MUL,   1'b0};
      ST_EMIT:   w = '{OP_EMIT,    C_OUT_FULL,   ST_EMIT,  1'b1};
      default:   w = '{OP_NONE,    C_NEVER,      ST_IDLE,  1'b1};
    endcase
    return w;
  endfunction

endpackage

FILE: src/ngl_div.sv
module ngl_div import ngl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [RAMP_W-1:0]    rem;
  logic [GAIN_W-1:0]    quo;
  logic [RAMP_W-1:0]    den;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  logic [RAMP_W:0] rem_sh;
  logic [RAMP_W:0] diff;
  logic            fit;

  // restoring step: shift in next dividend bit, subtract if it fits
  assign rem_sh = {rem, quo[GAIN_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign fit    = !diff[RAMP_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(GAIN_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= fit ? diff[RAMP_W-1:0] : rem_sh[RAMP_W-1:0];
      quo <= {quo[GAIN_W-2:0], fit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.quo  = quo;

endmodule

FILE: src/ngl_seq.sv
module ngl_seq import ngl_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output op_t     op
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uw;
  logic              jump;

  assign uw = ucode_rom(step);

  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = status.no_input;
      C_CH_MORE:    jump = status.ch_more;
      C_NOT_BYPASS: jump = status.not_bypass;
      C_NO_DIV:     jump = status.no_div;
      C_DIV_BUSY:   jump = status.div_busy;
      C_OUT_FULL:   jump = status.out_full;
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_next = uw.target;
    end else if (uw.last) begin
      step_next = ST_IDLE;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign op = uw.op;

endmodule

FILE: src/ngl_datapath.sv
module ngl_datapath import ngl_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24,
  parameter int IN_W        = 48,
  parameter int OUT_W       = 72
) (
  input  logic              clk,
  input  logic              rst,
  input  op_t               op,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_data,
  input  logic [THR_W-1:0]  threshold_level,
  input  logic [RAMP_W-1:0] ramp_steps,
  input  logic              bypass_on,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp,
  output status_t           status
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW   = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int PW   = SAMPLE_BITS + GAIN_W + 1;

  logic signed [SAMPLE_BITS-1:0] smp [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] res [CHANNELS];
  logic [CH_W-1:0]               ch;
  logic [SAMPLE_BITS-1:0]        det;
  logic signed [PW-1:0]          prod;
  logic [GAIN_W-1:0]             gain_app;

  // gate state
  logic [GAIN_W-1:0]       gain_now;
  logic                    gain_target;
  logic [RAMP_W-1:0]       ramp_left;
  logic signed [INC_W-1:0] ramp_inc;
  logic                    div_neg;

  logic signed [SAMPLE_BITS-1:0] smp_sel;
  logic [SAMPLE_BITS:0]          smp_neg;
  logic [SAMPLE_BITS-1:0]        mag;
  logic                          tgt_new;
  logic                          need_div;
  logic [GAIN_W-1:0]             goal;
  logic [GAIN_W-1:0]             goal_new;
  logic signed [GAIN_W+1:0]      gain_sum;
  logic [GAIN_W-1:0]             gain_step;
  logic [OUT_W-1:0]              pack;
  logic                          ch_last;
  logic                          accept;

  assign smp_sel = smp[ch];
  assign smp_neg = -{smp_sel[SAMPLE_BITS-1], smp_sel};
  assign mag     = smp_sel[SAMPLE_BITS-1] ? smp_neg[SAMPLE_BITS-1:0] : smp_sel;
  assign ch_last = (ch == CH_W'(CHANNELS - 1));
  assign accept  = (op == OP_LOAD) && in_valid;

  assign tgt_new  = (CW'(det) >= CW'(threshold_level));
  assign need_div = (tgt_new != gain_target) && (ramp_steps != '0);
  assign goal     = gain_target ? GAIN_ONE : '0;
  assign goal_new = tgt_new ? GAIN_ONE : '0;

  // ramp step with clamp to [0, 1.0]
  assign gain_sum = $signed({2'b00, gain_now}) + $signed({ramp_inc[INC_W-1], ramp_inc});
  always_comb begin
    if (gain_sum < 0) begin
      gain_step = '0;
    end else if (gain_sum > $signed({2'b00, GAIN_ONE})) begin
      gain_step = GAIN_ONE;
    end else begin
      gain_step = gain_sum[GAIN_W-1:0];
    end
  end

  // |goal - gain_now| with sign kept aside; the goal is either end of the range
  always_comb begin
    div_req.start = (op == OP_TARGET) && need_div;
    div_req.num   = tgt_new ? (GAIN_ONE - gain_now) : gain_now;
    div_req.den   = ramp_steps;
  end

  always_comb begin
    status.no_input   = !in_valid;
    status.ch_more    = !ch_last;
    status.not_bypass = !bypass_on;
    status.no_div     = !need_div;
    status.div_busy   = div_rsp.busy;
    status.out_full   = out_valid && !out_ready;
  end

  always_comb begin
    pack = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      pack[i*SAMPLE_BITS +: SAMPLE_BITS] = res[i];
    end
    pack[CHANNELS*SAMPLE_BITS +: GAIN_W] = gain_app;
  end

  // gate state and channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_now    <= GAIN_ONE;
      gain_target <= 1'b1;
      ramp_left   <= '0;
      ramp_inc    <= '0;
      ch          <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          if (accept) begin
            ch <= '0;
          end
        end
        OP_DET, OP_STORE: begin
          ch <= ch_last ? '0 : ch + 1'b1;
        end
        OP_TARGET: begin
          if (tgt_new != gain_target) begin
            gain_target <= tgt_new;
            if (ramp_steps == '0) begin
              gain_now  <= goal_new;
              ramp_left <= '0;
              ramp_inc  <= '0;
            end else begin
              ramp_left <= ramp_steps;
            end
          end
        end
        OP_DIVWAIT: begin
          if (!div_rsp.busy) begin
            ramp_inc <= div_neg ? -$signed({1'b0, div_rsp.quo})
                                : $signed({1'b0, div_rsp.quo});
          end
        end
        OP_ADVANCE: begin
          ch <= '0;
          if (ramp_left != '0) begin
            ramp_left <= ramp_left - 1'b1;
            gain_now  <= (ramp_left == RAMP_W'(1)) ? goal : gain_step;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (accept) begin
          for (int i = 0; i < CHANNELS; i++) begin
            smp[i] <= in_data[i*SAMPLE_BITS +: SAMPLE_BITS];
          end
          det <= '0;
        end
      end
      OP_DET: begin
        if (mag > det) begin
          det <= mag;
        end
      end
      OP_BYPASS: begin
        for (int i = 0; i < CHANNELS; i++) begin
          res[i] <= smp[i];
        end
        gain_app <= GAIN_ONE;
      end
      OP_TARGET: begin
        div_neg <= !tgt_new;
      end
      OP_ADVANCE: begin
        if (ramp_left == '0) begin
          gain_app <= goal;
        end else if (ramp_left == RAMP_W'(1)) begin
          gain_app <= goal;
        end else begin
          gain_app <= gain_step;
        end
      end
      OP_MUL: begin
        prod <= PW'(smp_sel) * PW'($signed({1'b0, gain_app}));
      end
      OP_STORE: begin
        res[ch] <= prod[GAIN_FRAC +: SAMPLE_BITS];
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT && !status.out_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && !status.out_full) begin
      out_data <= pack;
    end
  end

endmodule

FILE: src/noise_gate_linear_ramp.sv
// Noise gate with a linear gain ramp. Each word on the input stream carries one
// sample per channel; the largest magnitude is compared with threshold_level and
// sets the gate target open (gain 1.0) or closed (gain 0.0). A change of target
// starts a ramp of ramp_steps words that ends exactly on the target; a ramp
// length of zero switches at once. Every channel leaves as sample times gain,
// floored by 2^23, together with the Q1.23 gain applied. In bypass the samples
// pass unchanged with unity gain and the gate state is frozen. Words are handled
// one at a time by a small microcoded sequencer; a word that starts a ramp also
// waits for the bit-serial divider that works out the ramp increment. Output
// backpressure adds whatever time the result waits in the output register;
// the next word is taken in while it waits.
module noise_gate_linear_ramp import ngl_pkg::*; #(
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // fields from bit 0: sample_left, sample_right (one per channel), zero pad
  input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fields from bit 0: gated_left, gated_right (one per channel), gate_gain, zero pad
  output logic [((CHANNELS*SAMPLE_BITS+GAIN_W+7)/8)*8-1:0] m_axis_tdata,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IN_W  = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((CHANNELS * SAMPLE_BITS + GAIN_W + 7) / 8) * 8;

  logic [THR_W-1:0]  threshold_level;
  logic [RAMP_W-1:0] ramp_steps;
  logic              bypass_on;

  op_t      op;
  status_t  status;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // config registers; unlisted indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= THR_RESET;
      ramp_steps      <= RAMP_RESET;
      bypass_on       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold_level <= cfg_data[THR_W-1:0];
        REG_RAMP:      ramp_steps      <= cfg_data[RAMP_W-1:0];
        REG_BYPASS:    bypass_on       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // input is only taken at the idle step of the program
  assign s_axis_tready = (op == OP_LOAD);

  ngl_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  ngl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ngl_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .in_valid        (s_axis_tvalid),
    .in_data         (s_axis_tdata),
    .out_ready       (m_axis_tready),
    .out_valid       (m_axis_tvalid),
    .out_data        (m_axis_tdata),
    .threshold_level (threshold_level),
    .ramp_steps      (ramp_steps),
    .bypass_on       (bypass_on),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .status          (status)
  );

`ifndef SYNTH
  // no word is taken while the divider is still working
  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  // one word at a time: ready drops straight after a word is taken
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted back to back");

  // gain reported never exceeds unity
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[CHANNELS*SAMPLE_BITS +: GAIN_W] <= GAIN_ONE))
    else $error("gate gain above unity");
`endif

endmodule

FILE: sim/tb.sv
module tb;
  import ngl_pkg::*;

  localparam int SAMPLE_W    = 24;
  localparam int IN_BITS     = 2 * SAMPLE_W;           // two samples, already whole bytes
  localparam int OUT_BITS    = 2 * SAMPLE_W + GAIN_W;  // two samples and the gain
  localparam longint UNITY   = longint'(GAIN_ONE);
  localparam int STALL_LIMIT = 3000;                   // cycles with no handshake at all
  localparam int TAIL_CYCLES = 60;                     // slack after the last word, covering a ramp word
  localparam int CHUNK_WORDS = 30;

  // One output word; packed so that the left sample sits in the lowest bits of tdata
  typedef struct packed {
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } frame_t;

  typedef enum bit [0:0] {ROW_REG, ROW_WORD} row_kind_t;

  // Directed row: either a register write or a word, the latter with an optional
  // hand-typed result
  typedef struct packed {
    row_kind_t                  kind;
    reg_idx_t                   idx;
    logic [CFG_W-1:0]           val;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    bit                         pinned;
    frame_t                     pin;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_BITS-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Gate model state and its copy of the registers
  logic [THR_W-1:0]  thr_reg;
  logic [RAMP_W-1:0] ramp_reg;
  bit                byp_reg;
  longint            gain_q;
  bit                tgt_open;
  int unsigned       steps_left;
  longint            step_inc;

  frame_t      gate_q[$];   // expected output words, oldest first
  stim_row_t   stim_table[$];
  bit          cur_pinned = 1'b0;
  frame_t      cur_pin = '0;
  int          tx_idle_pct = 19;
  int          rx_idle_pct = 50;
  int          fails = 0;
  int          words_out = 0;
  int          quiet_cycles = 0;

  always #10 clk = ~clk;

  noise_gate_linear_ramp #(
    .CHANNELS    (2),
    .SAMPLE_BITS (SAMPLE_W)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Gate for one word: detector, target update, one ramp step, then scale.
  // Updates the model state unless bypassed.
  function automatic frame_t gate_frame(input logic signed [SAMPLE_W-1:0] l,
                                        input logic signed [SAMPLE_W-1:0] r);
    frame_t res;
    longint sl, sr, mag, goal, g, pl, pr;
    bit     want;
    sl  = longint'(l);
    sr  = longint'(r);
    mag = (sl < 0) ? -sl : sl;
    if (((sr < 0) ? -sr : sr) > mag) mag = (sr < 0) ? -sr : sr;
    if (byp_reg) begin
      res.left  = l;
      res.right = r;
      res.gain  = GAIN_ONE;
      return res;
    end
    // a repeated target leaves a running ramp alone
    want = (mag >= longint'(thr_reg));
    if (want != tgt_open) begin
      tgt_open = want;
      goal = want ? UNITY : 0;
      if (ramp_reg == 0) begin
        gain_q     = goal;
        steps_left = 0;
        step_inc   = 0;
      end else begin
        steps_left = 32'(ramp_reg);
        step_inc   = (goal - gain_q) / longint'(ramp_reg);  // truncates toward zero
      end
    end
    goal = tgt_open ? UNITY : 0;
    if (steps_left == 0) begin
      g = goal;
    end else begin
      steps_left--;
      // last step lands on the target exactly, whatever the rounding
      if (steps_left == 0) gain_q = goal;
      else gain_q += step_inc;
      if (gain_q < 0) gain_q = 0;
      if (gain_q > UNITY) gain_q = UNITY;
      g = gain_q;
    end
    pl = (sl * g) >>> GAIN_FRAC;   // arithmetic shift floors
    pr = (sr * g) >>> GAIN_FRAC;
    res.left  = pl[SAMPLE_W-1:0];
    res.right = pr[SAMPLE_W-1:0];
    res.gain  = g[GAIN_W-1:0];
    return res;
  endfunction

  function automatic void table_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    stim_table.push_back(row);
  endfunction

  function automatic void table_word(input logic signed [SAMPLE_W-1:0] l,
                                     input logic signed [SAMPLE_W-1:0] r);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WORD;
    row.l    = l;
    row.r    = r;
    stim_table.push_back(row);
  endfunction

  function automatic void table_pinned(input logic signed [SAMPLE_W-1:0] l,
                                       input logic signed [SAMPLE_W-1:0] r,
                                       input logic signed [SAMPLE_W-1:0] el,
                                       input logic signed [SAMPLE_W-1:0] er,
                                       input logic [GAIN_W-1:0] eg);
    stim_row_t row;
    row           = '0;
    row.kind      = ROW_WORD;
    row.l         = l;
    row.r         = r;
    row.pinned    = 1'b1;
    row.pin.left  = el;
    row.pin.right = er;
    row.pin.gain  = eg;
    stim_table.push_back(row);
  endfunction

  // Sample below the threshold (none exists at threshold zero)
  function automatic logic signed [SAMPLE_W-1:0] quiet_sample();
    logic signed [SAMPLE_W-1:0] v;
    v = (thr_reg == 0) ? '0 : SAMPLE_W'($urandom_range(thr_reg - 1, 0));
    if ($urandom_range(1, 0)) v = -v;
    return v;
  endfunction

  // Sample at or above the threshold; 2^23 wraps to full-scale negative
  function automatic logic signed [SAMPLE_W-1:0] loud_sample();
    logic signed [SAMPLE_W-1:0] v;
    v = SAMPLE_W'($urandom_range(32'd8388608, thr_reg));
    if ($urandom_range(1, 0)) v = -v;
    return v;
  endfunction

  // All tasks below start and end on a falling edge
  task automatic send_word(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r,
                           input bit pinned, input frame_t pin);
    while ($urandom_range(99, 0) < tx_idle_pct) @(negedge clk);
    s_tdata    = {r, l};
    cur_pinned = pinned;
    cur_pin    = pin;
    s_tvalid   = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain();
    s_tvalid = 1'b0;
    while (gate_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      REG_THRESHOLD: thr_reg  = val[THR_W-1:0];
      REG_RAMP:      ramp_reg = val[RAMP_W-1:0];
      REG_BYPASS:    byp_reg  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Runs of loud and quiet words so that the target flips often, ramps run out
  // or get cut short, with some fully random words mixed in
  task automatic random_words(input int n);
    int k;
    int run;
    bit loud;
    logic signed [SAMPLE_W-1:0] l, r;
    k = 0;
    while (k < n) begin
      loud = 1'($urandom_range(1, 0));
      run  = $urandom_range(8, 1);
      repeat (run) begin
        if (k < n) begin
          if ($urandom_range(99, 0) < 15) begin
            l = SAMPLE_W'($urandom);
            r = SAMPLE_W'($urandom);
          end else if (loud && $urandom_range(1, 0)) begin
            l = loud_sample();
            r = quiet_sample();
          end else if (loud) begin
            l = quiet_sample();
            r = loud_sample();
          end else begin
            l = quiet_sample();
            r = quiet_sample();
          end
          send_word(l, r, 1'b0, '0);
          k++;
        end
      end
    end
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Predict on every accepted input word, check every accepted output word
  always @(posedge clk) begin
    frame_t pred;
    frame_t want;
    frame_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred = gate_frame($signed(s_tdata[SAMPLE_W-1:0]),
                          $signed(s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
        gate_q.push_back(cur_pinned ? cur_pin : pred);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (gate_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("output word %0d with nothing expected: left %0d right %0d gain %0d",
                     words_out, got.left, got.right, got.gain);
        end else begin
          want = gate_q.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.gain !== want.gain) begin
            fails++;
            if (fails <= 10)
              $display("output word %0d: exp left %0d right %0d gain %0d, got %0d %0d %0d",
                       words_out, want.left, want.right, want.gain,
                       got.left, got.right, got.gain);
          end
        end
        words_out++;
      end
    end
  end

  // Watchdog: no handshake on either stream for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    thr_reg    = THR_RESET;
    ramp_reg   = RAMP_RESET;
    byp_reg    = 1'b0;
    gain_q     = UNITY;
    tgt_open   = 1'b1;
    steps_left = 0;
    step_inc   = 0;

    // out of reset: threshold zero, gate open at unity, words pass as they are
    table_pinned(0, 0, 0, 0, GAIN_ONE);
    table_pinned(8388607, -8388608, 8388607, -8388608, GAIN_ONE);
    table_pinned(-1, 1, -1, 1, GAIN_ONE);
    // zero ramp length: gain switches at once; top threshold
    table_reg(REG_RAMP, 0);
    table_reg(REG_THRESHOLD, 8388607);
    table_pinned(8388606, -8388606, 0, 0, '0);
    // full-scale negative is above any threshold
    table_pinned(-8388608, 0, -8388608, 0, GAIN_ONE);
    // magnitude equal to the threshold opens
    table_pinned(8388607, 5, 8388607, 5, GAIN_ONE);
    table_pinned(100, -100, 0, 0, '0);
    // bypass: unchanged words at unity, gate stays closed underneath
    table_reg(REG_BYPASS, 1);
    table_pinned(123456, -654321, 123456, -654321, GAIN_ONE);
    table_pinned(-8388608, 8388607, -8388608, 8388607, GAIN_ONE);
    table_reg(REG_BYPASS, 0);
    table_pinned(-5, 7, 0, 0, '0);
    // short ramps, target flipped mid-ramp, steps that do not divide evenly
    table_reg(REG_RAMP, 3);
    table_reg(REG_THRESHOLD, 1000);
    table_word(2000, -3);
    table_word(0, 0);
    // new ramp length does not touch the ramp in progress
    table_reg(REG_RAMP, 65535);
    table_word(0, 0);
    table_word(-999, 999);
    table_word(1000, 0);
    table_word(-8388608, -8388608);
    table_reg(REG_RAMP, 1);
    table_word(0, 0);
    table_word(8388607, 8388607);
    table_reg(REG_RAMP, 2);
    table_word(0, 0);
    table_word(5000, -5000);
    table_word(-1, 1);
    table_word(-8388608, 8388607);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_REG) begin
        drain();
        write_reg(row.idx, row.val);
      end else begin
        send_word(row.l, row.r, row.pinned, row.pin);
      end
    end

    // three idling phases, each in chunks with fresh settings between them
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 50 : 0;
      rx_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 19 : 0;
      for (int c = 0; c < 5; c++) begin
        drain();
        case ($urandom_range(5, 0))
          0:       write_reg(REG_THRESHOLD, 0);
          1:       write_reg(REG_THRESHOLD, 8388607);
          default: write_reg(REG_THRESHOLD,
                             CFG_W'($urandom_range(8388607, 0) >> $urandom_range(20, 0)));
        endcase
        // mostly short ramps; now and then none, the longest, or a middling one
        case ($urandom_range(9, 0))
          0:       write_reg(REG_RAMP, 0);
          1:       write_reg(REG_RAMP, 65535);
          2:       write_reg(REG_RAMP, CFG_W'($urandom_range(600, 9)));
          default: write_reg(REG_RAMP, CFG_W'($urandom_range(8, 1)));
        endcase
        write_reg(REG_BYPASS, CFG_W'($urandom_range(7, 0) == 0));
        random_words(CHUNK_WORDS);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && gate_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
